// File: hdl/stream_find_and_replace_core_assert.svh
// assertion macros for the find and replace core
// expects clk and rst_n in the scope of the module that uses them
`ifndef STREAM_FIND_AND_REPLACE_CORE_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFR_ASSERT(label, prop, msg)
`define SFR_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: hdl/sfr_pkg.sv
// shared types, constants and helpers for the find and replace core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int MAX_BURST       = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                     MAX_PATTERN : MAX_REPLACEMENT;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int FILL_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W     = $clog2(MAX_BURST + 1);

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic sel_new;
        logic load;
        logic slide;
    } cell_ctl_t;

    typedef struct packed {
        logic [MAX_BURST-1:0][CHAR_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic                             present;
        logic                             last;
    } burst_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] lim);
        return (len > lim) ? lim : len;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sfr_stream_if.sv
// stream channels of the find and replace core: input characters and result words
// depends on sfr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sfr_char_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;

    modport source (output valid, in_char, in_last, input ready);
    modport sink (input valid, in_char, in_last, output ready);
endinterface

interface sfr_result_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              out_present;
    logic              out_end;

    modport source (output valid, out_char, out_present, out_end, input ready);
    modport sink (input valid, out_char, out_present, out_end, output ready);
endinterface

`default_nettype wire

// File: hdl/stream_find_and_replace_core.sv
// top level of the streaming find and replace core: config registers and glue
// depends on sfr_pkg, sfr_stream_if, sfr_window and sfr_outq
//
//  channel        dir  words                               handshake
//  char_stream    in   in_char[7:0], in_last               valid / ready
//  result_stream  out  out_char[7:0], out_present, out_end valid / ready
//  cfg_*          in   cfg_index[1:0], cfg_data[63:0]      cfg_write_en, no wait
//
// one input word per cycle while each word gives at most one result and result_stream.ready is high
// a word that gives more than one result holds char_stream.ready low while the result
// queue sends all but the last of them, one word per cycle while result_stream.ready is high
// while one result waits, char_stream.ready follows result_stream.ready
// reset clears the config registers, the window fill and the queue
// a write to pattern_length empties the window
`timescale 1ns / 1ps
`default_nettype none

module stream_find_and_replace_core import sfr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sfr_char_if.sink             char_stream,
    sfr_result_if.source         result_stream
);

    logic [CFG_W-1:0] pat_reg;
    logic [LEN_W-1:0] plen_reg;
    logic [CFG_W-1:0] rep_reg;
    logic [LEN_W-1:0] rlen_reg;
    logic             accept;
    logic             load_ok;
    logic             clear_fill;
    burst_t           burst;

    assign char_stream.ready = load_ok;
    assign accept     = char_stream.valid && load_ok;
    assign clear_fill = cfg_write_en && (cfg_index == REG_PATTERN_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            plen_reg <= '0;
            rep_reg  <= '0;
            rlen_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:      pat_reg  <= cfg_data;
                REG_PATTERN_LENGTH:     plen_reg <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  rep_reg  <= cfg_data;
                REG_REPLACEMENT_LENGTH: rlen_reg <= cfg_data[LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    sfr_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .new_char   (char_stream.in_char),
        .last       (char_stream.in_last),
        .clear_fill (clear_fill),
        .plen       (clamp_len(plen_reg, LEN_W'(MAX_PATTERN))),
        .rlen       (clamp_len(rlen_reg, LEN_W'(MAX_REPLACEMENT))),
        .pat_bytes  (pat_reg),
        .rep_bytes  (rep_reg),
        .burst      (burst)
    );

    sfr_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .burst   (burst),
        .load_ok (load_ok),
        .res     (result_stream)
    );

endmodule

`default_nettype wire

// File: hdl/sfr_cell.sv
// one window cell: holds one byte, compares it with its pattern byte
// depends on sfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfr_cell import sfr_pkg::*; (
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [CHAR_W-1:0] new_char,
    input  logic [CHAR_W-1:0] nbr_view,
    input  logic [CHAR_W-1:0] pat_char,
    output logic [CHAR_W-1:0] view,
    output logic              eq
);

    logic [CHAR_W-1:0] byte_reg;

    assign view = ctl.sel_new ? new_char : byte_reg;
    assign eq   = (view == pat_char);

    always_ff @(posedge clk)
    begin
        if (ctl.slide)
        begin
            byte_reg <= nbr_view;
        end
        else if (ctl.load && ctl.sel_new)
        begin
            byte_reg <= new_char;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sfr_window.sv
// sliding match window: chain of cells, fill count, match test and burst build
// depends on sfr_pkg and sfr_cell
`timescale 1ns / 1ps
`default_nettype none

module sfr_window import sfr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] new_char,
    input  logic              last,
    input  logic              clear_fill,
    input  logic [LEN_W-1:0]  plen,
    input  logic [LEN_W-1:0]  rlen,
    input  logic [CFG_W-1:0]  pat_bytes,
    input  logic [CFG_W-1:0]  rep_bytes,
    output burst_t            burst
);

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]   fill_new;
    logic               full;
    logic               hit;
    logic               slide;
    logic               active;
    logic [MAX_PATTERN-1:0]             eq;
    logic [MAX_PATTERN-1:0][CHAR_W-1:0] cell_view;
    cell_ctl_t [MAX_PATTERN-1:0]        cell_ctl;

    assign active   = (plen != '0);
    assign fill_new = LEN_W'(fill_reg) + LEN_W'(1);
    assign full     = (fill_new == plen);
    assign slide    = accept && active && full && !hit && !last;

    always_comb
    begin
        hit = full;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((LEN_W'(i) < plen) && !eq[i])
            begin
                hit = 1'b0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            logic [CHAR_W-1:0] nbr;

            if (g == MAX_PATTERN - 1)
            begin : g_end
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_view[g+1];
            end

            assign cell_ctl[g].sel_new = (LEN_W'(fill_reg) == LEN_W'(g));
            assign cell_ctl[g].load    = accept && active;
            assign cell_ctl[g].slide   = slide;

            sfr_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[g]),
                .new_char (new_char),
                .nbr_view (nbr),
                .pat_char (pat_bytes[CHAR_W*g +: CHAR_W]),
                .view     (cell_view[g]),
                .eq       (eq[g])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (clear_fill)
        begin
            fill_next = '0;
        end
        else if (accept && active)
        begin
            if (last || hit)
            begin
                fill_next = '0;
            end
            else if (full)
            begin
                fill_next = FILL_W'(plen - LEN_W'(1));
            end
            else
            begin
                fill_next = FILL_W'(fill_new);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        burst.bytes   = '0;
        burst.count   = '0;
        burst.present = 1'b1;
        burst.last    = last;
        if (!active)
        begin
            burst.bytes[0] = new_char;
            burst.count    = CNT_W'(1);
        end
        else if (hit)
        begin
            for (int i = 0; i < MAX_BURST; i++)
            begin
                if (i < MAX_REPLACEMENT)
                begin
                    burst.bytes[i] = rep_bytes[CHAR_W*i +: CHAR_W];
                end
            end
            burst.count = CNT_W'(rlen);
        end
        else
        begin
            for (int i = 0; i < MAX_BURST; i++)
            begin
                if (i < MAX_PATTERN)
                begin
                    burst.bytes[i] = cell_view[i];
                end
            end
            if (last)
            begin
                burst.count = CNT_W'(fill_new);
            end
            else if (full)
            begin
                burst.count = CNT_W'(1);
            end
        end
        // end of text with nothing to send: bare end mark
        if (last && (burst.count == '0))
        begin
            burst.bytes   = '0;
            burst.count   = CNT_W'(1);
            burst.present = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sfr_outq.sv
// result shift queue: holds one burst and sends it one word per cycle while res.ready is high
// depends on sfr_pkg, sfr_stream_if and the assertion macros
`include "stream_find_and_replace_core_assert.svh"
`timescale 1ns / 1ps
`default_nettype none

module sfr_outq import sfr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  burst_t              burst,
    output logic                load_ok,
    sfr_result_if.source        res
);

    logic [MAX_BURST-1:0][CHAR_W-1:0] byte_reg, byte_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             present_reg, present_next;
    logic                             end_reg, end_next;
    logic                             drain;

    assign drain   = res.valid && res.ready;
    assign load_ok = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && res.ready);

    assign res.valid       = (cnt_reg != '0);
    assign res.out_char    = byte_reg[0];
    assign res.out_present = present_reg;
    assign res.out_end     = end_reg && (cnt_reg == CNT_W'(1));

    always_comb
    begin
        byte_next    = byte_reg;
        cnt_next     = cnt_reg;
        present_next = present_reg;
        end_next     = end_reg;
        if (drain)
        begin
            for (int i = 0; i < MAX_BURST - 1; i++)
            begin
                byte_next[i] = byte_reg[i+1];
            end
            byte_next[MAX_BURST-1] = '0;
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (load)
        begin
            byte_next    = burst.bytes;
            cnt_next     = burst.count;
            present_next = burst.present;
            end_next     = burst.last;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            present_reg <= 1'b0;
            end_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            present_reg <= present_next;
            end_reg     <= end_next;
        end
    end

    `SFR_ASSERT(a_cnt_bound, (cnt_reg <= CNT_W'(MAX_BURST)), "queue count overflow")
    `SFR_ASSERT(a_load_free, load |-> ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && res.ready)), "burst loaded over pending words")
    `SFR_ASSERT(a_bare_alone, (res.valid && !res.out_present) |-> res.out_end, "bare word without end mark")

endmodule

`default_nettype wire

// File: dv/tb_stream_find_and_replace_core.sv
// testbench for stream_find_and_replace_core: directed and random texts, checked word by word
// against an in-bench replace predictor; depends on sfr_pkg and the sfr stream interfaces
`timescale 1ns / 1ps

module tb_stream_find_and_replace_core;
    import sfr_pkg::*;

    localparam int RANDOM_ITEMS = 140;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_present;
        logic              out_end;
    } result_word_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    logic                 char_valid   = 1'b0;
    logic [CHAR_W-1:0]    char_data    = '0;
    logic                 char_last    = 1'b0;
    logic                 result_ready = 1'b0;

    sfr_char_if   chars ();
    sfr_result_if results ();

    assign chars.valid   = char_valid;
    assign chars.in_char = char_data;
    assign chars.in_last = char_last;
    assign results.ready = result_ready;

    stream_find_and_replace_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .char_stream   (chars),
        .result_stream (results)
    );

    always #2 clk = ~clk;

    // predictor state and register copy
    logic [CFG_W-1:0]  pat_bytes = '0;
    logic [LEN_W-1:0]  pat_len   = '0;
    logic [CFG_W-1:0]  rep_bytes = '0;
    logic [LEN_W-1:0]  rep_len   = '0;
    logic [CHAR_W-1:0] window_bytes [MAX_PATTERN];
    int unsigned       window_fill = 0;

    text_word_t   pending_chars [$];
    result_word_t expected_words [$];
    text_word_t   next_word;
    result_word_t oldest_word;

    int unsigned items_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_left      = 0;
    int unsigned hold_request   = 0;
    int unsigned hold_served    = 0;
    bit          quiet_phase    = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic queue_result(input logic [CHAR_W-1:0] ch, input logic present);
        result_word_t w;
        w.out_char    = ch;
        w.out_present = present;
        w.out_end     = 1'b0;
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic predict_replace(input logic [CHAR_W-1:0] ch, input logic last);
        int unsigned plen;
        int unsigned rlen;
        int unsigned first_idx;
        bit          hit;
        plen      = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
        rlen      = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len;
        first_idx = expected_words.size();
        if (plen == 0)
            queue_result(ch, 1'b1);
        else
        begin
            window_bytes[window_fill] = ch;
            window_fill++;
            if (window_fill == plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (window_bytes[i] != pat_bytes[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                        queue_result(rep_bytes[8*i +: 8], 1'b1);
                    window_fill = 0;
                end
                else
                begin
                    queue_result(window_bytes[0], 1'b1);
                    for (int i = 1; i < plen; i++)
                        window_bytes[i-1] = window_bytes[i];
                    window_fill = plen - 1;
                end
            end
            if (last)
            begin
                for (int i = 0; i < window_fill; i++)
                    queue_result(window_bytes[i], 1'b1);
                window_fill = 0;
            end
        end
        if (last)
        begin
            if (expected_words.size() == first_idx)
                queue_result('0, 1'b0);
            expected_words[expected_words.size()-1].out_end = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
                               input logic [CHAR_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $error("%s expected %0h actual %0h", name, want, got);
        end
    endtask

    // word source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_data  <= '0;
            char_last  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (char_valid && chars.ready)
                predict_replace(char_data, char_last);
            if (!char_valid || chars.ready)
            begin
                if (send_gap != 0 || pending_chars.size() == 0)
                begin
                    if (send_gap != 0)
                        send_gap--;
                    char_valid <= 1'b0;
                end
                else
                begin
                    next_word = pending_chars.pop_front();
                    char_valid <= 1'b1;
                    char_data  <= next_word.ch;
                    char_last  <= next_word.last;
                    send_gap = pick_gap();
                end
            end
        end
    end

    // result sink and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (results.valid && result_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected result word: out_char %0h out_present %0b out_end %0b",
                           results.out_char, results.out_present, results.out_end);
                end
                else
                begin
                    oldest_word = expected_words.pop_front();
                    check_field("out_char", oldest_word.out_char, results.out_char);
                    check_field("out_present", oldest_word.out_present, results.out_present);
                    check_field("out_end", oldest_word.out_end, results.out_end);
                end
            end
            if (hold_request != hold_served)
            begin
                hold_left   = hold_request;
                hold_served = hold_request;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_text_word(input logic [CHAR_W-1:0] ch, input logic last);
        text_word_t w;
        w.ch   = ch;
        w.last = last;
        pending_chars.insert(pending_chars.size(), w);
        items_sent++;
    endtask

    task automatic wait_idle();
        while (pending_chars.size() != 0 || char_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        case (idx)
            REG_PATTERN_BYTES:     pat_bytes = value;
            REG_PATTERN_LENGTH:
            begin
                pat_len     = value[LEN_W-1:0];
                window_fill = 0;
            end
            REG_REPLACEMENT_BYTES: rep_bytes = value;
            default:               rep_len = value[LEN_W-1:0];
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] random_reg_value(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] v;
        int unsigned      r;
        v = {$urandom, $urandom};
        r = $urandom_range(0, 19);
        case (idx)
            REG_PATTERN_BYTES:
                for (int i = 0; i < MAX_PATTERN; i++)
                    if ($urandom_range(0, 3) != 0)
                        v[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 3));
            REG_PATTERN_LENGTH:
                if (r == 0)       v = '0;
                else if (r <= 13) v = CFG_W'($urandom_range(1, 4));
                else if (r <= 16) v = CFG_W'($urandom_range(5, MAX_PATTERN));
                else              v = CFG_W'($urandom_range(MAX_PATTERN + 1, 15));
            REG_REPLACEMENT_LENGTH:
                if (r <= 3)       v = '0;
                else if (r <= 13) v = CFG_W'($urandom_range(1, 4));
                else if (r <= 16) v = CFG_W'(MAX_REPLACEMENT);
                else              v = CFG_W'($urandom_range(MAX_REPLACEMENT + 1, 15));
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_random_reg(input logic [CFG_IDX_W-1:0] idx);
        write_reg(idx, random_reg_value(idx));
    endtask

    // texts built from pattern runs, pattern prefixes and stray bytes; noise texts are all random
    task automatic send_random_text(input int len, input int split_at, input bit noise);
        int unsigned       plen;
        int unsigned       run_left;
        int unsigned       run_pos;
        int unsigned       pick;
        int                produced;
        logic [CHAR_W-1:0] next_char;
        plen     = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
        run_left = 0;
        run_pos  = 0;
        produced = 0;
        while (produced < len)
        begin
            if (run_left == 0 && !noise && plen != 0)
            begin
                pick = $urandom_range(0, 9);
                run_pos = 0;
                if (pick < 3)
                    run_left = plen;
                else if (pick < 5)
                    run_left = $urandom_range(1, plen);
            end
            if (run_left != 0)
            begin
                next_char = pat_bytes[8*run_pos +: 8];
                run_pos++;
                run_left--;
            end
            else if (!noise && plen != 0 && $urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, plen - 1);
                next_char = pat_bytes[8*pick +: 8];
            end
            else
                next_char = CHAR_W'($urandom_range(0, 255));
            if (split_at != 0 && produced == split_at)
            begin
                wait_idle();
                write_random_reg(CFG_IDX_W'($urandom_range(0, 3)));
            end
            push_text_word(next_char, produced == len - 1);
            produced++;
        end
    endtask

    initial
    begin
        int unsigned random_start;
        int unsigned text_count;
        int          text_len;
        int          split_at;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pass through with registers at reset values
        push_text_word(8'h00, 1'b0);
        push_text_word(8'hff, 1'b1);
        wait_idle();

        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
        // match inside a text, partial match flushed at the end
        push_text_word("z", 1'b0);
        push_text_word("a", 1'b0);
        push_text_word("b", 1'b0);
        push_text_word("c", 1'b0);
        push_text_word("a", 1'b0);
        push_text_word("b", 1'b1);
        // single word text, window never full
        push_text_word("q", 1'b1);
        wait_idle();

        // deleting replacement, final word gives a bare end mark
        write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
        push_text_word("a", 1'b0);
        push_text_word("b", 1'b0);
        push_text_word("c", 1'b1);
        wait_idle();

        // length rewrite mid-text drops the held window
        push_text_word("a", 1'b0);
        push_text_word("b", 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        push_text_word("c", 1'b1);
        wait_idle();

        // pattern and replacement rewrite mid-text keep the window
        push_text_word("a", 1'b0);
        push_text_word("b", 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0064_6261);
        write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_005a);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd1);
        push_text_word("d", 1'b1);
        wait_idle();

        // oversized lengths clamp to the maximum
        write_reg(REG_PATTERN_BYTES, {CFG_W{1'b1}});
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
        for (int i = 0; i < MAX_PATTERN; i++)
            push_text_word(8'hff, i == MAX_PATTERN - 1);
        wait_idle();

        random_start = items_sent;
        text_count   = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (text_count % 4 == 0)
            begin
                if (text_count == 0 || $urandom_range(0, 2) != 0)
                    write_random_reg(REG_PATTERN_BYTES);
                if (text_count == 0 || $urandom_range(0, 2) != 0)
                    write_random_reg(REG_PATTERN_LENGTH);
                if (text_count == 0 || $urandom_range(0, 2) != 0)
                    write_random_reg(REG_REPLACEMENT_BYTES);
                if (text_count == 0 || $urandom_range(0, 2) != 0)
                    write_random_reg(REG_REPLACEMENT_LENGTH);
            end
            quiet_phase = ($urandom_range(0, 4) == 0);
            if (text_count == 3)
            begin
                // long receiver hold while the sender streams back to back
                quiet_phase  = 1'b1;
                hold_request = HOLD_CYCLES;
                send_random_text(40, 0, 1'b1);
            end
            else
            begin
                text_len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30)
                                                       : $urandom_range(1, 10);
                split_at = (text_len > 1 && $urandom_range(0, 5) == 0)
                           ? $urandom_range(1, text_len - 1) : 0;
                send_random_text(text_len, split_at, $urandom_range(0, 4) == 0);
            end
            wait_idle();
            text_count++;
        end

        wait_idle();
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
